/* design/mtb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the median threshold binarizer.
// No dependencies; every other file imports this package.
package mtb_pkg;

  localparam int MAX_PIXELS = 1048576;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int LEVELS     = 256;
  localparam int LVL_W      = $clog2(LEVELS);

  localparam logic [CNT_W-1:0] MAX_CNT      = CNT_W'(MAX_PIXELS);
  localparam logic [LVL_W-1:0] LVL_MAX      = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] THRESH_RESET = LVL_W'(123);
  localparam logic [LVL_W-1:0] PIX_ON       = LVL_W'(255);
  localparam logic [LVL_W-1:0] PIX_OFF      = LVL_W'(0);

  localparam logic OP_STATS    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Histogram write port
  typedef struct packed {
    logic             en;
    logic [LVL_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } hist_wr_t;

  // Rank unit control
  typedef struct packed {
    logic             clear;
    logic             acc;
    logic [LVL_W-1:0] idx;
  } rank_ctl_t;

  // Rank unit result: levels at the lower and upper middle rank
  typedef struct packed {
    logic [LVL_W-1:0] lvl_a;
    logic [LVL_W-1:0] lvl_b;
  } rank_res_t;

endpackage

/* design/mtb_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel beats in and result beats out.
// Depends on mtb_pkg for field widths.
interface mtb_in_if;
  import mtb_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [LVL_W-1:0] red_level;
  logic             frame_end;

  modport source (output valid, operation, red_level, frame_end, input ready);
  modport sink   (input valid, operation, red_level, frame_end, output ready);
endinterface

interface mtb_out_if;
  import mtb_pkg::*;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] out_value;
  logic             is_threshold;
  logic             overflowed;

  modport source (output valid, out_value, is_threshold, overflowed, input ready);
  modport sink   (input valid, out_value, is_threshold, overflowed, output ready);
endinterface

/* design/mtb_hist_mem.sv */
`timescale 1ns / 1ps
// Histogram store: one write and one registered read port per cycle,
// per-bin valid flags so clr_all clears the whole frame without a pass over the bins. Uses mtb_pkg.
module mtb_hist_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mtb_pkg::LVL_W-1:0]    rd_addr,
  output logic [mtb_pkg::CNT_W-1:0]    rd_bin,
  input  mtb_pkg::hist_wr_t            wr,
  input  logic                         clr_all
);
  import mtb_pkg::*;

  logic [CNT_W-1:0] mem_r [LEVELS];
  logic [LEVELS-1:0] valid_r;
  logic [CNT_W-1:0] rd_q_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // A bin never written since the last clear reads as zero
  assign rd_bin = rd_valid_r ? rd_q_r : '0;

endmodule

/* design/mtb_rank_unit.sv */
`timescale 1ns / 1ps
// Shared accumulate-and-compare unit: running sum of bins against two ranks.
// Uses mtb_pkg.
module mtb_rank_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mtb_pkg::rank_ctl_t        ctl,
  input  logic [mtb_pkg::CNT_W-1:0] bin,
  input  logic [mtb_pkg::CNT_W-1:0] rank_a,
  input  logic [mtb_pkg::CNT_W-1:0] rank_b,
  output mtb_pkg::rank_res_t        res
);
  import mtb_pkg::*;

  logic [CNT_W-1:0] cum_r, cum_nxt;
  logic [LVL_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic             a_hit_r, a_hit_nxt, b_hit_r, b_hit_nxt;

  always_comb begin
    cum_nxt   = cum_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    a_hit_nxt = a_hit_r;
    b_hit_nxt = b_hit_r;
    if (ctl.clear) begin
      cum_nxt   = '0;
      a_nxt     = LVL_MAX;
      b_nxt     = LVL_MAX;
      a_hit_nxt = 1'b0;
      b_hit_nxt = 1'b0;
    end else if (ctl.acc) begin
      cum_nxt = cum_r + bin;
      // latch the first level whose running sum passes each rank
      if (!a_hit_r && (cum_nxt > rank_a)) begin
        a_nxt     = ctl.idx;
        a_hit_nxt = 1'b1;
      end
      if (!b_hit_r && (cum_nxt > rank_b)) begin
        b_nxt     = ctl.idx;
        b_hit_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cum_r   <= '0;
      a_r     <= LVL_MAX;
      b_r     <= LVL_MAX;
      a_hit_r <= 1'b0;
      b_hit_r <= 1'b0;
    end else begin
      cum_r   <= cum_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      a_hit_r <= a_hit_nxt;
      b_hit_r <= b_hit_nxt;
    end
  end

  assign res.lvl_a = a_r;
  assign res.lvl_b = b_r;

endmodule

/* design/median_threshold_binarizer.sv */
`timescale 1ns / 1ps
// Top level of the median threshold binarizer: sequencer, counters, output register.
// Depends on mtb_pkg, mtb_if, mtb_hist_mem and mtb_rank_unit.
//
// Usage: a frame is streamed twice over in_bus. Statistics beats (operation 0)
// add red_level to a 256-bin histogram; the beat with frame_end set closes the
// pass and, after a scan of all bins, one beat with is_threshold = 1 carries the
// median threshold. Classification beats (operation 1) each return one beat:
// 255 if red_level is above the threshold, else 0. overflowed reports samples
// dropped once the pass reached MAX_PIXELS.
// Flow: a classification beat's result is registered and shows the next
// cycle. A kept statistics beat reads its bin on acceptance, then S_UPD writes
// it back incremented; a dropped one stays in S_IDLE unless it ends the frame.
// At frame end the scan streams all 256 bins through the shared rank adder,
// then the threshold beat is emitted; no beat is taken meanwhile.
// Reset: histogram valid flags, counters and flags clear together; the
// threshold starts at 123. No clearing pass is needed.
// Stall: results sit in a single output register; in_bus.ready drops outside
// S_IDLE and while that register is full and out_bus.ready is low.
module median_threshold_binarizer (
  input  logic       clk,
  input  logic       rst_n,
  mtb_in_if.sink     in_bus,
  mtb_out_if.source  out_bus
);
  import mtb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LVL_W-1:0] thr_r, thr_nxt;
  logic [LVL_W-1:0] red_r, red_nxt;
  logic             last_r, last_nxt;
  logic [LVL_W:0]   scan_cnt_r, scan_cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [LVL_W-1:0] data_idx_r, data_idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0] out_value_r, out_value_nxt;
  logic             out_thr_r, out_thr_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             out_free;
  logic             in_fire;
  logic [LVL_W-1:0] rd_addr;
  logic [CNT_W-1:0] rd_bin;
  hist_wr_t         hist_wr;
  logic             hist_clr;
  rank_ctl_t        rank_ctl;
  rank_res_t        rank_res;
  logic [CNT_W-1:0] half, rank_a;
  logic [LVL_W:0]   mid_sum;

  assign out_free     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE) && out_free;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Middle ranks: odd count uses one, even count the pair below and at half
  assign half    = cnt_r >> 1;
  assign rank_a  = cnt_r[0] ? half : (half - CNT_W'(1));
  assign mid_sum = {1'b0, rank_res.lvl_a} + {1'b0, rank_res.lvl_b};

  // Idle reads the incoming bin, the scan reads bins in order
  assign rd_addr = (state_r == S_IDLE) ? in_bus.red_level : scan_cnt_r[LVL_W-1:0];

  mtb_hist_mem u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_bin  (rd_bin),
    .wr      (hist_wr),
    .clr_all (hist_clr)
  );

  mtb_rank_unit u_rank (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (rank_ctl),
    .bin    (rd_bin),
    .rank_a (rank_a),
    .rank_b (half),
    .res    (rank_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    thr_nxt       = thr_r;
    red_nxt       = red_r;
    last_nxt      = last_r;
    scan_cnt_nxt  = scan_cnt_r;
    pend_nxt      = pend_r;
    data_idx_nxt  = data_idx_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_value_nxt = out_value_r;
    out_thr_nxt   = out_thr_r;
    out_ovf_nxt   = out_ovf_r;
    hist_wr.en    = 1'b0;
    hist_wr.addr  = red_r;
    hist_wr.data  = rd_bin + CNT_W'(1);
    hist_clr      = 1'b0;
    rank_ctl.clear = 1'b0;
    rank_ctl.acc   = pend_r;
    rank_ctl.idx   = data_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_bus.operation == OP_CLASSIFY) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = (in_bus.red_level > thr_r) ? PIX_ON : PIX_OFF;
            out_thr_nxt   = 1'b0;
            out_ovf_nxt   = ovf_r;
          end else begin
            red_nxt  = in_bus.red_level;
            last_nxt = in_bus.frame_end;
            if (cnt_r < MAX_CNT) begin
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = S_UPD;
            end else begin
              // capacity reached: drop the sample, still honor frame end
              ovf_nxt = 1'b1;
              if (in_bus.frame_end) begin
                state_nxt      = S_SCAN;
                scan_cnt_nxt   = '0;
                pend_nxt       = 1'b0;
                rank_ctl.clear = 1'b1;
              end
            end
          end
        end
      end
      S_UPD: begin
        hist_wr.en = 1'b1;
        if (last_r) begin
          state_nxt      = S_SCAN;
          scan_cnt_nxt   = '0;
          pend_nxt       = 1'b0;
          rank_ctl.clear = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // issue one bin read per cycle; its data feeds the rank unit next cycle
        if (!scan_cnt_r[LVL_W]) begin
          scan_cnt_nxt = scan_cnt_r + (LVL_W + 1)'(1);
          pend_nxt     = 1'b1;
          data_idx_nxt = scan_cnt_r[LVL_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && (data_idx_r == LVL_MAX)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          thr_nxt       = mid_sum[LVL_W:1];
          out_valid_nxt = 1'b1;
          out_value_nxt = mid_sum[LVL_W:1];
          out_thr_nxt   = 1'b1;
          out_ovf_nxt   = ovf_r;
          // drop the frame's statistics
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          hist_clr      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      thr_r       <= THRESH_RESET;
      scan_cnt_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      thr_r       <= thr_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    red_r       <= red_nxt;
    last_r      <= last_nxt;
    data_idx_r  <= data_idx_nxt;
    out_value_r <= out_value_nxt;
    out_thr_r   <= out_thr_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_value    = out_value_r;
  assign out_bus.is_threshold = out_thr_r;
  assign out_bus.overflowed   = out_ovf_r;

  // Sample count never passes capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("sample count above capacity");

  // Emitting the threshold clears the frame statistics
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && out_free |=> (cnt_r == '0) && !ovf_r && out_thr_r)
    else $error("statistics not cleared after threshold beat");

  // Count holds steady while the histogram is scanned
  a_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && (state_nxt == S_SCAN) |=> $stable(cnt_r))
    else $error("sample count moved during scan");

  // Classification beats carry only black or white
  a_binary_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_thr_r |-> (out_value_r == PIX_ON) || (out_value_r == PIX_OFF))
    else $error("classification beat not binary");

endmodule

/* tb/tb_median_threshold_binarizer.sv */
`timescale 1ns / 1ps
// Self-checking bench for median_threshold_binarizer: directed table, random frames.
// Depends on mtb_pkg, mtb_if and the design top level.
module tb_median_threshold_binarizer;
  import mtb_pkg::*;

  // Run limit: far above the length of a fully stalled run.
  localparam longint LIMIT_NS = 100_000_000;
  localparam int     BEATS_PER_PHASE = 180;
  localparam int     SETTLE_CYCLES = 300;  // covers the threshold scan
  localparam int     REPORT_MAX = 10;

  typedef struct packed {
    logic             op;
    logic [LVL_W-1:0] red;
    logic             last;
  } pixel_t;

  typedef struct packed {
    logic [LVL_W-1:0] value;
    logic             thr;
    logic             ovf;
  } result_t;

  // One row of the directed table; typed = 1 means the expected beat is written out.
  typedef struct packed {
    logic    typed;
    pixel_t  px;
    result_t res;
  } stim_row_t;

  localparam int NUM_ROWS = 25;

  logic clk = 1'b0;
  logic rst_n;

  mtb_in_if  in_bus();
  mtb_out_if out_bus();

  median_threshold_binarizer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #6 clk = ~clk;

  // Histogram shadow and running threshold.
  int unsigned      bin_count [LEVELS];
  int unsigned      kept_samples;
  logic             dropped_flag;
  logic [LVL_W-1:0] live_threshold;

  result_t awaited_beats [$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      beats_sent;

  // Directed table. After reset the threshold is 123; each single-sample frame sets
  // it to that sample; even counts take the floor of the two middle levels.
  stim_row_t directed_rows [NUM_ROWS] = '{
    // classify around the reset threshold, frame_end on a classify beat is ignored
    '{1'b1, '{OP_CLASSIFY, 8'd123, 1'b0}, '{PIX_OFF, 1'b0, 1'b0}},
    '{1'b1, '{OP_CLASSIFY, 8'd124, 1'b0}, '{PIX_ON,  1'b0, 1'b0}},
    '{1'b1, '{OP_CLASSIFY, 8'd0,   1'b0}, '{PIX_OFF, 1'b0, 1'b0}},
    '{1'b1, '{OP_CLASSIFY, 8'd255, 1'b1}, '{PIX_ON,  1'b0, 1'b0}},
    // single-sample frame at the low extreme
    '{1'b1, '{OP_STATS,    8'd0,   1'b1}, '{8'd0,    1'b1, 1'b0}},
    '{1'b1, '{OP_CLASSIFY, 8'd0,   1'b0}, '{PIX_OFF, 1'b0, 1'b0}},
    '{1'b1, '{OP_CLASSIFY, 8'd1,   1'b0}, '{PIX_ON,  1'b0, 1'b0}},
    // single-sample frame at the high extreme: nothing can be above it
    '{1'b1, '{OP_STATS,    8'd255, 1'b1}, '{8'd255,  1'b1, 1'b0}},
    '{1'b1, '{OP_CLASSIFY, 8'd255, 1'b0}, '{PIX_OFF, 1'b0, 1'b0}},
    // even count
    '{1'b0, '{OP_STATS,    8'd10,  1'b0}, '{8'd0,    1'b0, 1'b0}},
    '{1'b1, '{OP_STATS,    8'd20,  1'b1}, '{8'd15,   1'b1, 1'b0}},
    // even count spanning both extremes rounds down
    '{1'b0, '{OP_STATS,    8'd0,   1'b0}, '{8'd0,    1'b0, 1'b0}},
    '{1'b1, '{OP_STATS,    8'd255, 1'b1}, '{8'd127,  1'b1, 1'b0}},
    // odd count with a classify beat in the middle of the pass
    '{1'b0, '{OP_STATS,    8'd3,   1'b0}, '{8'd0,    1'b0, 1'b0}},
    '{1'b0, '{OP_STATS,    8'd7,   1'b0}, '{8'd0,    1'b0, 1'b0}},
    '{1'b1, '{OP_CLASSIFY, 8'd200, 1'b0}, '{PIX_ON,  1'b0, 1'b0}},
    '{1'b1, '{OP_STATS,    8'd5,   1'b1}, '{8'd5,    1'b1, 1'b0}},
    '{1'b0, '{OP_STATS,    8'd9,   1'b0}, '{8'd0,    1'b0, 1'b0}},
    '{1'b1, '{OP_STATS,    8'd1,   1'b1}, '{8'd5,    1'b1, 1'b0}},
    '{1'b1, '{OP_CLASSIFY, 8'd5,   1'b0}, '{PIX_OFF, 1'b0, 1'b0}},
    '{1'b1, '{OP_CLASSIFY, 8'd6,   1'b1}, '{PIX_ON,  1'b0, 1'b0}},
    '{1'b0, '{OP_STATS,    8'd254, 1'b0}, '{8'd0,    1'b0, 1'b0}},
    '{1'b1, '{OP_STATS,    8'd255, 1'b1}, '{8'd254,  1'b1, 1'b0}},
    '{1'b0, '{OP_CLASSIFY, 8'd128, 1'b0}, '{8'd0,    1'b0, 1'b0}},
    '{1'b0, '{OP_STATS,    8'd128, 1'b1}, '{8'd0,    1'b0, 1'b0}}
  };

  function automatic pixel_t mk_pixel(input logic op, input logic [LVL_W-1:0] red,
                                      input logic last);
    pixel_t px;
    px.op   = op;
    px.red  = red;
    px.last = last;
    return px;
  endfunction

  // Smallest level whose cumulative count passes the zero-based rank.
  function automatic logic [LVL_W-1:0] level_at_rank(input int unsigned rank);
    int unsigned cum;
    cum = 0;
    for (int v = 0; v < LEVELS; v++) begin
      cum += bin_count[v];
      if (cum > rank) return LVL_W'(v);
    end
    return LVL_MAX;
  endfunction

  // Advance the shadow state by one accepted beat; return 1 if it yields a result.
  function automatic bit median_binarize(input pixel_t px, output result_t res);
    int unsigned half;
    int unsigned lo_lvl;
    int unsigned hi_lvl;
    res = '0;
    if (px.op == OP_CLASSIFY) begin
      res.value = (px.red > live_threshold) ? PIX_ON : PIX_OFF;
      res.thr   = 1'b0;
      res.ovf   = dropped_flag;
      return 1'b1;
    end
    if (kept_samples < MAX_PIXELS) begin
      bin_count[px.red]++;
      kept_samples++;
    end else begin
      dropped_flag = 1'b1;
    end
    if (!px.last) return 1'b0;
    if (kept_samples > 0) begin
      half = kept_samples / 2;
      if (kept_samples % 2 == 0) begin
        lo_lvl = level_at_rank(half - 1);
        hi_lvl = level_at_rank(half);
        live_threshold = LVL_W'((lo_lvl + hi_lvl) / 2);
      end else begin
        live_threshold = level_at_rank(half);
      end
    end
    res.value = live_threshold;
    res.thr   = 1'b1;
    res.ovf   = dropped_flag;
    foreach (bin_count[i]) bin_count[i] = 0;
    kept_samples = 0;
    dropped_flag = 1'b0;
    return 1'b1;
  endfunction

  // Drive one beat from a falling edge, wait for the handshake, predict at acceptance.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_beat(input pixel_t px, input bit use_typed = 1'b0,
                           input result_t typed_res = '0);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= px.op;
    in_bus.red_level <= px.red;
    in_bus.frame_end <= px.last;
    do @(posedge clk); while (!in_bus.ready);
    if (median_binarize(px, res))
      awaited_beats.insert(awaited_beats.size(), use_typed ? typed_res : res);
    beats_sent++;
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted beat has come back.
  task automatic hold_until_drained();
    in_bus.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(negedge clk);
  endtask

  function automatic logic [LVL_W-1:0] clamp_level(input int lvl);
    if (lvl < 0) return PIX_OFF;
    if (lvl > LEVELS - 1) return LVL_MAX;
    return LVL_W'(lvl);
  endfunction

  // One statistics pass with random content, then a run of classify beats.
  task automatic send_frame();
    int          n;
    int          mix;
    int          base;
    int          span;
    bit          closes;
    logic [LVL_W-1:0] lvl;
    n      = ($urandom_range(15) == 0) ? $urandom_range(300, 100) : $urandom_range(40, 1);
    mix    = $urandom_range(3);
    base   = $urandom_range(255);
    span   = $urandom_range(7);
    closes = ($urandom_range(9) != 0);  // leave some passes open to merge with the next
    for (int i = 0; i < n; i++) begin
      // stray classify beat in the middle of a pass
      if ($urandom_range(19) == 0)
        send_beat(mk_pixel(OP_CLASSIFY, 8'($urandom), 1'($urandom)));
      case (mix)
        0: lvl = 8'($urandom);
        1: lvl = clamp_level(base + int'($urandom_range(span)));
        2: lvl = $urandom_range(1) ? LVL_MAX : PIX_OFF;
        default: lvl = clamp_level(base - 16 + int'($urandom_range(32)));
      endcase
      send_beat(mk_pixel(OP_STATS, lvl, (i == n - 1) && closes));
    end
    if ($urandom_range(7) == 0) hold_until_drained();
    n = $urandom_range(30, 1);
    for (int i = 0; i < n; i++) begin
      // hit just below, at and above the live threshold half the time
      if ($urandom_range(1))
        lvl = clamp_level(int'(live_threshold) + int'($urandom_range(2)) - 1);
      else
        lvl = 8'($urandom);
      send_beat(mk_pixel(OP_CLASSIFY, lvl, 1'($urandom)));
    end
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct);
    int start;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start = beats_sent;
    while (beats_sent - start < BEATS_PER_PHASE) send_frame();
    hold_until_drained();
  endtask

  // Receiver stalls change at the falling edge, like every other input.
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every accepted result beat against the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.value = out_bus.out_value;
      got.thr   = out_bus.is_threshold;
      got.ovf   = out_bus.overflowed;
      if (awaited_beats.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: unexpected result beat value=%0d thr=%b ovf=%b",
                   $realtime, got.value, got.thr, got.ovf);
        mismatches++;
      end else begin
        want = awaited_beats.pop_front();
        if (got.value !== want.value || got.thr !== want.thr || got.ovf !== want.ovf) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: mismatch exp value=%0d thr=%b ovf=%b got value=%0d thr=%b ovf=%b",
                     $realtime, want.value, want.thr, want.ovf,
                     got.value, got.thr, got.ovf);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_median_threshold_binarizer NOT OK");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_STATS;
    in_bus.red_level = '0;
    in_bus.frame_end = 1'b0;
    out_bus.ready    = 1'b0;
    mismatches       = 0;
    beats_sent       = 0;
    send_idle_pct    = 18;
    recv_idle_pct    = 82;
    foreach (bin_count[i]) bin_count[i] = 0;
    kept_samples   = 0;
    dropped_flag   = 1'b0;
    live_threshold = THRESH_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender idles lightly, receiver stalls heavily: directed rows, then random frames.
    foreach (directed_rows[r])
      send_beat(directed_rows[r].px, directed_rows[r].typed, directed_rows[r].res);
    hold_until_drained();
    run_phase(18, 82);
    // Swap the pressure: sparse beats into an eager receiver.
    run_phase(82, 18);
    // Full rate both ways.
    run_phase(0, 0);

    in_bus.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_beats.size() == 0) begin
      $display("tb_median_threshold_binarizer OK");
    end else begin
      $display("tb_median_threshold_binarizer NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
design/mtb_pkg.sv
design/mtb_if.sv
design/mtb_hist_mem.sv
design/mtb_rank_unit.sv
design/median_threshold_binarizer.sv
tb/tb_median_threshold_binarizer.sv
